// File: hw/rtl/parr_pkg.sv
// Shared constants and codes for the pixel aspect ratio reduction block.
`default_nettype none
package parr_pkg;

   // Width kept of every ratio term and every dimension.
   localparam int DIM_BITS   = 16;
   // Width of a product term, of the divider datapath and of the GCD terms.
   localparam int PROD_BITS  = 2 * DIM_BITS;
   localparam int CNT_BITS   = $clog2(PROD_BITS);

   // Fixed field widths at the ports.
   localparam int FIELD_BITS = 16;
   localparam int OUT_BITS   = 32;
   localparam int STAT_BITS  = 2;
   localparam int REQ_BITS   = 4 * FIELD_BITS;
   localparam int RSP_BITS   = 2 * OUT_BITS;
   localparam int CSR_ADDR_BITS = 1;

   // Result status codes.
   localparam logic [STAT_BITS-1:0] STATUS_SKIP = 2'd0;
   localparam logic [STAT_BITS-1:0] STATUS_DONE = 2'd1;
   localparam logic [STAT_BITS-1:0] STATUS_ERR  = 2'd2;

   // Register indexes.
   localparam logic [CSR_ADDR_BITS-1:0] REG_HEADER_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HEADER_HEIGHT = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/pixel_aspect_ratio_reduce.sv
// Steps: a skipped item goes from acceptance straight to the output state, and a zero
// divisor goes from GCHK to it. Otherwise MULX and MULY form the products, then Euclid
// remainder steps (GCHK, GDIV) and the two exact divisions (DIVX, DIVY) run on one
// shared radix-2 divider before OUT. One item at a time; req_tready is high only when
// idle, and OUT holds while an earlier result waits on rsp_tready.
// Synchronous active-high reset clears control state and both header registers.
`default_nettype none
module pixel_aspect_ratio_reduce (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // csr
   input  wire logic                                  csr_we,
   input  wire logic [parr_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [parr_pkg::FIELD_BITS-1:0]       csr_wdata,
   // request
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // disp_ratio_x, disp_ratio_y, frame_width, frame_height
   input  wire logic [parr_pkg::REQ_BITS-1:0]         req_tdata,
   // response
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // pixel_ratio_num, pixel_ratio_den
   output logic [parr_pkg::RSP_BITS-1:0]              rsp_tdata,
   // status
   output logic [parr_pkg::STAT_BITS-1:0]             rsp_tuser
);

   localparam int DB = parr_pkg::DIM_BITS;
   localparam int PB = parr_pkg::PROD_BITS;
   localparam int CB = parr_pkg::CNT_BITS;
   localparam int FB = parr_pkg::FIELD_BITS;
   localparam int OB = parr_pkg::OUT_BITS;
   localparam logic [CB-1:0] CNT_LAST = CB'(PB - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MULX = 3'd1;
   localparam logic [2:0] S_MULY = 3'd2;
   localparam logic [2:0] S_GCHK = 3'd3;
   localparam logic [2:0] S_GDIV = 3'd4;
   localparam logic [2:0] S_DIVX = 3'd5;
   localparam logic [2:0] S_DIVY = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [FB-1:0] hdr_w_ff, hdr_w_in, hdr_h_ff, hdr_h_in;
   logic [DB-1:0] dx_ff, dx_in, dy_ff, dy_in, w_ff, w_in, h_ff, h_in;
   logic [PB-1:0] px_ff, px_in, py_ff, py_in;
   logic [PB-1:0] a_ff, a_in, b_ff, b_in;
   logic [PB-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [OB-1:0] num_ff, num_in, den_ff, den_in;
   logic [parr_pkg::STAT_BITS-1:0] stat_ff, stat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [parr_pkg::RSP_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [parr_pkg::STAT_BITS-1:0] rsp_user_ff, rsp_user_in;

   logic          accept;
   logic [DB-1:0] in_dx, in_dy, in_w, in_h;
   logic [FB-1:0] sel_w, sel_h;
   logic [DB-1:0] mul_a, mul_b;
   logic [PB-1:0] prod;
   logic [PB:0]   rem_sh, diff;
   logic          ge;
   logic [PB-1:0] rem_nx, quo_nx;
   logic          div_last;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // field unpack, zero width/height picks the header value
   always_comb begin
      in_dx = DB'(req_tdata[FB-1:0]);
      in_dy = DB'(req_tdata[2*FB-1:FB]);
      sel_w = (req_tdata[3*FB-1:2*FB] == '0) ? hdr_w_ff : req_tdata[3*FB-1:2*FB];
      sel_h = (req_tdata[4*FB-1:3*FB] == '0) ? hdr_h_ff : req_tdata[4*FB-1:3*FB];
      in_w  = DB'(sel_w);
      in_h  = DB'(sel_h);
   end

   // shared multiplier
   always_comb begin
      mul_a = (state_ff == S_MULX) ? dx_ff : dy_ff;
      mul_b = (state_ff == S_MULX) ? h_ff : w_ff;
      prod  = PB'(mul_a) * PB'(mul_b);
   end

   // shared restoring divider step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[PB-1]};
      diff     = rem_sh - {1'b0, dvs_ff};
      ge       = !diff[PB];
      rem_nx   = ge ? diff[PB-1:0] : rem_sh[PB-1:0];
      quo_nx   = {quo_ff[PB-2:0], ge};
      div_last = (cnt_ff == CNT_LAST);
   end

   always_comb begin
      state_in     = state_ff;
      hdr_w_in     = hdr_w_ff;
      hdr_h_in     = hdr_h_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_we) begin
         unique case (csr_addr)
            parr_pkg::REG_HEADER_WIDTH:  hdr_w_in = csr_wdata;
            parr_pkg::REG_HEADER_HEIGHT: hdr_h_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dx_in = in_dx;
               dy_in = in_dy;
               w_in  = in_w;
               h_in  = in_h;
               if (in_dx == '0 || in_dy == '0) begin
                  num_in   = '0;
                  den_in   = '0;
                  stat_in  = parr_pkg::STATUS_SKIP;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MULX;
               end
            end
         end
         S_MULX: begin
            px_in    = prod;
            a_in     = prod;
            state_in = S_MULY;
         end
         S_MULY: begin
            py_in    = prod;
            b_in     = prod;
            state_in = S_GCHK;
         end
         S_GCHK: begin
            rem_in = '0;
            cnt_in = '0;
            if (b_ff == '0) begin
               if (a_ff == '0) begin
                  num_in   = '0;
                  den_in   = '0;
                  stat_in  = parr_pkg::STATUS_ERR;
                  state_in = S_OUT;
               end else begin
                  // gcd found: divide px by it
                  quo_in   = px_ff;
                  dvs_in   = a_ff;
                  state_in = S_DIVX;
               end
            end else begin
               quo_in   = a_ff;
               dvs_in   = b_ff;
               state_in = S_GDIV;
            end
         end
         S_GDIV: begin
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               a_in     = dvs_ff;
               b_in     = rem_nx;
               state_in = S_GCHK;
            end
         end
         S_DIVX: begin
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               num_in   = OB'(quo_nx);
               rem_in   = '0;
               quo_in   = py_ff;
               cnt_in   = '0;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               den_in   = OB'(quo_nx);
               stat_in  = parr_pkg::STATUS_DONE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {den_ff, num_ff};
               rsp_user_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hdr_w_ff     <= '0;
         hdr_h_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hdr_w_ff     <= hdr_w_in;
         hdr_h_ff     <= hdr_h_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/parr_checker.sv
// Port-level assertions for the pixel aspect ratio reduction block, with bind.
`default_nettype none
module parr_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  csr_we,
   input wire logic [parr_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input wire logic [parr_pkg::FIELD_BITS-1:0]       csr_wdata,
   input wire logic                                  req_tvalid,
   input wire logic                                  req_tready,
   input wire logic [parr_pkg::REQ_BITS-1:0]         req_tdata,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [parr_pkg::RSP_BITS-1:0]         rsp_tdata,
   input wire logic [parr_pkg::STAT_BITS-1:0]        rsp_tuser
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == parr_pkg::STATUS_SKIP ||
                      rsp_tuser == parr_pkg::STATUS_DONE ||
                      rsp_tuser == parr_pkg::STATUS_ERR))
      else $error("undefined status code");

   // ratio fields are zero unless the reduction completed
   a_zero_unless_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != parr_pkg::STATUS_DONE) |-> (rsp_tdata == '0))
      else $error("nonzero ratio on skipped or failed transaction");

   // a completed reduction always has a nonzero term
   a_done_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == parr_pkg::STATUS_DONE) |-> (rsp_tdata != '0))
      else $error("completed reduction with both terms zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind pixel_aspect_ratio_reduce parr_checker u_parr_checker (.*);
`default_nettype wire
